FILE: sv/sensor_pattern_subscription_table_assert.svh
// assertion helpers, clocked on clk_i and quiet during reset
`ifndef SENSOR_PATTERN_SUBSCRIPTION_TABLE_ASSERT_SVH
`define SENSOR_PATTERN_SUBSCRIPTION_TABLE_ASSERT_SVH

`ifndef SYNTH
`define SPST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define SPST_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SPST_ASSERT(lbl, prop)
`define SPST_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: sv/spst_pkg.sv
package spst_pkg;

  localparam int MaxResults = 4;
  localparam int CntBits    = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [31:0] sensor_word;
    logic        sub_valid;
    logic [7:0]  sub_id;
    logic [31:0] sub_mask;
    logic [31:0] sub_pattern;
  } tick_t;

  typedef struct packed {
    logic [7:0] fired_id;
    logic [1:0] fired_slot;
    logic       last_fired;
  } fire_t;

  // head of the tick queue as seen by the table engine
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } tick_beat_t;

endpackage

FILE: sv/spst_stream_if.sv
interface spst_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/spst_front.sv
module spst_front
  import spst_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  spst_stream_if.sink   tick_i,
  output tick_beat_t    head_o,
  input  logic          pop_i
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  tick_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign tick_i.ready = (cnt_q != CntW'(Depth));
  assign push         = tick_i.valid && tick_i.ready;
  assign pop          = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.tick  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= tick_i.data;
    end
  end

endmodule

FILE: sv/spst_back.sv
`include "sensor_pattern_subscription_table_assert.svh"

module spst_back
  import spst_pkg::*;
#(
  parameter int SLOTS   = 4,
  parameter int ID_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tick_beat_t    head_i,
  output logic          pop_o,
  spst_stream_if.source fire_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StFire = 1'b1;

  logic                state_q, state_d;
  logic [SLOTS-1:0]    valid_q, valid_d;
  logic [SLOTS-1:0]    hits_q, hits_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [ID_BITS-1:0]  id_q [SLOTS];
  logic [31:0]         mask_q [SLOTS];
  logic [31:0]         pat_q [SLOTS];
  logic                out_valid_q, out_valid_d;
  fire_t               out_q;

  tick_t               tick;
  logic [ID_BITS-1:0]  new_id;
  logic                free_found, dup, ins, take, new_match;
  logic [SlotW-1:0]    free_idx;
  logic [SLOTS-1:0]    hit_vec;

  logic                pick_found, last, out_free, emit;
  logic [SlotW-1:0]    pick;
  logic [SLOTS-1:0]    pick_oh, rest;

  assign tick      = head_i.tick;
  assign new_id    = ID_BITS'(tick.sub_id);
  assign take      = (state_q == StIdle) && head_i.valid;
  assign pop_o     = take;
  assign new_match = ((tick.sensor_word & tick.sub_mask) == tick.sub_pattern);

  // insertion search stops at the first free slot or at a valid slot with the same id
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    dup        = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (!free_found && !dup) begin
        if (!valid_q[k]) begin
          free_found = 1'b1;
          free_idx   = SlotW'(k);
        end else if (id_q[k] == new_id) begin
          dup = 1'b1;
        end
      end
    end
    ins = tick.sub_valid && free_found && !dup;
  end

  // match vector of the table as it stands after insertion
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      hit_vec[k] = (valid_q[k] && ((tick.sensor_word & mask_q[k]) == pat_q[k]))
                || (ins && (free_idx == SlotW'(k)) && new_match);
    end
  end

  always_comb begin
    pick_found = 1'b0;
    pick       = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (hits_q[k] && !pick_found) begin
        pick_found = 1'b1;
        pick       = SlotW'(k);
      end
    end
    pick_oh = '0;
    pick_oh[pick] = pick_found;
    rest = hits_q & ~pick_oh;
    last = (rest == '0) || (cnt_q == CntBits'(MaxResults - 1));
  end

  assign out_free = !out_valid_q || fire_o.ready;
  assign emit     = (state_q == StFire) && out_free;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    hits_d      = hits_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (fire_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (take) begin
          if (ins) begin
            valid_d[free_idx] = 1'b1;
          end
          hits_d  = hit_vec;
          cnt_d   = '0;
          state_d = (hit_vec != '0) ? StFire : StIdle;
        end
      end
      StFire: begin
        if (emit) begin
          valid_d[pick] = 1'b0;
          out_valid_d   = 1'b1;
          cnt_d         = cnt_q + CntBits'(1);
          hits_d        = last ? '0 : rest;
          if (last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      hits_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      hits_q      <= hits_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ins) begin
      id_q[free_idx]   <= new_id;
      mask_q[free_idx] <= tick.sub_mask;
      pat_q[free_idx]  <= tick.sub_pattern;
    end
    if (emit) begin
      out_q.fired_id   <= 8'(id_q[pick]);
      out_q.fired_slot <= 2'(pick);
      out_q.last_fired <= last;
    end
  end

  assign fire_o.valid = out_valid_q;
  assign fire_o.data  = out_q;

  `SPST_ASSERT(a_fire_has_hit, (state_q == StFire) |-> (hits_q != '0))
  `SPST_ASSERT(a_pick_is_live, emit |-> valid_q[pick])
  `SPST_ASSERT(a_last_ends_tick, (emit && last) |=> (state_q == StIdle))
  `SPST_ASSERT_NEVER(a_cnt_bound, cnt_q > CntBits'(MaxResults))

endmodule

FILE: sv/sensor_pattern_subscription_table.sv
// Subscription table for sensor patterns. Each tick beat carries a 32-bit sensor word
// and optionally a new subscription (id, mask, pattern); it is stored in the first free
// slot unless a valid slot before that free slot has the same id, or the table is full.
// Then every valid slot whose masked sensors equal its pattern fires, lowest slot first,
// and is cleared; at most four fire per tick and last_fired marks the final one. Ticks
// are queued two deep in front of the table engine. The engine does the insertion and
// the match of all slots in one step, then sends one fired result per cycle through
// its single output register while the result side does not stall; the next tick waits
// for the last result. SLOTS sets the table size and ID_BITS the stored id width.
module sensor_pattern_subscription_table
  import spst_pkg::*;
#(
  parameter int SLOTS   = 4,
  parameter int ID_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spst_stream_if.sink   tick_i,
  spst_stream_if.source fire_o
);

  tick_beat_t head;
  logic       pop;

  spst_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_i),
    .head_o (head),
    .pop_i  (pop)
  );

  spst_back #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .fire_o (fire_o)
  );

endmodule
